@@ src/i2cbm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and constants of the bit-level i2c master: opcodes, decoded
// commands, sequencer states, queue item and result beat layouts.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

  // input opcodes as they arrive on the port
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // register indexes (paddr bit 2 selects the word)
  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  // register reset values
  localparam logic [7:0] PHASE_TICKS_RST = 8'd2;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  // bits per byte on the bus
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // default depth of the command queue
  localparam int QUEUE_DEPTH = 4;

  // decoded command
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  // bus sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ST_A,
    S_ST_B,
    S_SP_A,
    S_SP_B,
    S_SP_C,
    S_WR_LO,
    S_WR_HI,
    S_AK_LO,
    S_AK_WAIT,
    S_RD_LO,
    S_RD_HI,
    S_MA_LO,
    S_MA_HI
  } seq_state_t;

  // one classified tick waiting in the queue
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic       sda_in;
  } q_item_t;

  // one result beat
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } res_t;

  // configuration handed to the sequencer
  typedef struct packed {
    logic [7:0] phase_ticks;
    logic [7:0] ack_timeout;
  } cfg_t;

endpackage

@@ src/i2cbm_front.sv @@
// ----------------------------------------------------------------------------
// i2cbm_front
// Front end: classifies the opcode of each input beat into a command and
// packs the beat into a queue item.
// ----------------------------------------------------------------------------
module i2cbm_front
  import i2cbm_pkg::*;
(
  input  logic [2:0] opcode,
  input  logic [7:0] tx_byte,
  input  logic       send_nack,
  input  logic       sda_in,
  output q_item_t    item
);

  cmd_t cmd;

  // opcode decode, unused codes act as a plain tick
  always_comb begin
    case (opcode)
      OP_START: cmd = CMD_START;
      OP_STOP:  cmd = CMD_STOP;
      OP_WRITE: cmd = CMD_WRITE;
      OP_READ:  cmd = CMD_READ;
      default:  cmd = CMD_NONE;
    endcase
  end

  // pack the beat
  always_comb begin
    item.cmd       = cmd;
    item.tx_byte   = tx_byte;
    item.send_nack = send_nack;
    item.sda_in    = sda_in;
  end

endmodule

@@ src/i2cbm_queue.sv @@
// ----------------------------------------------------------------------------
// i2cbm_queue
// Short fifo of classified beats between the front end and the sequencer.
// ----------------------------------------------------------------------------
module i2cbm_queue
  import i2cbm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output q_item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  q_item_t       mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic do_push;
  logic do_pop;

  assign full      = (count == FULL_COUNT);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/i2cbm_seq.sv @@
// ----------------------------------------------------------------------------
// i2cbm_seq
// Back end: the bus sequencer. Takes one queued tick a cycle if unstalled,
// advances scl/sda phases and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module i2cbm_seq
  import i2cbm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  q_item_t q_item,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_stall,
  output res_t    res
);

  seq_state_t seq_state, seq_state_next;
  logic [7:0] phase_count, phase_count_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] wait_count, wait_count_next;
  logic       nack_flag, nack_flag_next;
  logic [1:0] line_levels, line_levels_next;
  logic       err_flag, err_flag_next;
  logic [7:0] rx_hold, rx_hold_next;
  logic       done;

  logic       step;
  logic [7:0] pt;
  logic [7:0] phase_inc;
  logic       phase_end;
  logic [3:0] bit_inc;
  logic       last_bit;

  assign step      = q_valid && (!out_valid || !out_stall);
  assign q_pop     = step;
  assign pt        = (cfg.phase_ticks == '0) ? 8'd1 : cfg.phase_ticks;
  assign phase_inc = phase_count + 8'd1;
  assign phase_end = (phase_inc >= pt);
  assign bit_inc   = bit_count + 4'd1;
  assign last_bit  = (bit_inc >= BYTE_BITS);

  // next state
  always_comb begin
    seq_state_next = seq_state;
    if (step) begin
      case (seq_state)
        S_IDLE: begin
          case (q_item.cmd)
            CMD_START: seq_state_next = S_ST_A;
            CMD_STOP:  seq_state_next = S_SP_A;
            CMD_WRITE: seq_state_next = S_WR_LO;
            CMD_READ:  seq_state_next = S_RD_LO;
            default:   seq_state_next = S_IDLE;
          endcase
        end
        S_AK_WAIT: begin
          if (!q_item.sda_in) begin
            seq_state_next = S_IDLE;
          end else if (wait_count >= cfg.ack_timeout) begin
            seq_state_next = S_SP_A;
          end
        end
        default: begin
          if (phase_end) begin
            case (seq_state)
              S_ST_A:  seq_state_next = S_ST_B;
              S_SP_A:  seq_state_next = S_SP_B;
              S_SP_B:  seq_state_next = S_SP_C;
              S_WR_LO: seq_state_next = S_WR_HI;
              S_WR_HI: seq_state_next = last_bit ? S_AK_LO : S_WR_LO;
              S_AK_LO: seq_state_next = S_AK_WAIT;
              S_RD_LO: seq_state_next = S_RD_HI;
              S_RD_HI: seq_state_next = last_bit ? S_MA_LO : S_RD_LO;
              S_MA_LO: seq_state_next = S_MA_HI;
              default: seq_state_next = S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  // counters, shift register and flags
  always_comb begin
    phase_count_next = phase_count;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    wait_count_next  = wait_count;
    nack_flag_next   = nack_flag;
    err_flag_next    = err_flag;
    rx_hold_next     = rx_hold;
    done             = 1'b0;
    if (step) begin
      case (seq_state)
        S_IDLE: begin
          case (q_item.cmd)
            CMD_WRITE: begin
              shift_reg_next = q_item.tx_byte;
              bit_count_next = '0;
              err_flag_next  = 1'b0;
            end
            CMD_READ: begin
              shift_reg_next = '0;
              bit_count_next = '0;
              nack_flag_next = q_item.send_nack;
            end
            default: ;
          endcase
          phase_count_next = '0;
        end
        S_AK_WAIT: begin
          if (!q_item.sda_in) begin
            done             = 1'b1;
            phase_count_next = '0;
          end else if (wait_count >= cfg.ack_timeout) begin
            err_flag_next    = 1'b1;
            phase_count_next = '0;
          end else begin
            wait_count_next = wait_count + 8'd1;
          end
        end
        default: begin
          if (phase_end) begin
            phase_count_next = '0;
            case (seq_state)
              S_WR_HI: begin
                shift_reg_next = {shift_reg[6:0], 1'b0};
                bit_count_next = bit_inc;
              end
              S_RD_HI: begin
                shift_reg_next = {shift_reg[6:0], q_item.sda_in};
                bit_count_next = bit_inc;
                if (last_bit) begin
                  rx_hold_next = {shift_reg[6:0], q_item.sda_in};
                end
              end
              S_AK_LO: wait_count_next = '0;
              default: ;
            endcase
            if (seq_state == S_ST_B || seq_state == S_SP_C || seq_state == S_MA_HI) begin
              done = 1'b1;
            end
          end else begin
            phase_count_next = phase_inc;
          end
        end
      endcase
    end
  end

  // line levels: {scl, sda} set on every change of state
  always_comb begin
    line_levels_next = line_levels;
    if (step && (seq_state_next != seq_state)) begin
      case (seq_state_next)
        S_IDLE: begin
          case (seq_state)
            S_ST_B:    line_levels_next = 2'b00;
            S_MA_HI:   line_levels_next = {1'b0, nack_flag};
            S_AK_WAIT: line_levels_next = 2'b01;
            default:   line_levels_next = 2'b11;
          endcase
        end
        S_ST_A:    line_levels_next = 2'b11;
        S_ST_B:    line_levels_next = 2'b10;
        S_SP_A:    line_levels_next = 2'b00;
        S_SP_B:    line_levels_next = 2'b10;
        S_SP_C:    line_levels_next = 2'b11;
        S_WR_LO:   line_levels_next = {1'b0, shift_reg_next[7]};
        S_WR_HI:   line_levels_next = {1'b1, shift_reg_next[7]};
        S_AK_LO:   line_levels_next = 2'b01;
        S_AK_WAIT: line_levels_next = 2'b11;
        S_RD_LO:   line_levels_next = 2'b01;
        S_RD_HI:   line_levels_next = 2'b11;
        S_MA_LO:   line_levels_next = {1'b0, nack_flag_next};
        S_MA_HI:   line_levels_next = {1'b1, nack_flag_next};
        default:   line_levels_next = 2'b11;
      endcase
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state   <= S_IDLE;
      phase_count <= '0;
      bit_count   <= '0;
      shift_reg   <= '0;
      wait_count  <= '0;
      nack_flag   <= 1'b0;
      line_levels <= 2'b11;
      err_flag    <= 1'b0;
      rx_hold     <= '0;
    end else begin
      seq_state   <= seq_state_next;
      phase_count <= phase_count_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      wait_count  <= wait_count_next;
      nack_flag   <= nack_flag_next;
      line_levels <= line_levels_next;
      err_flag    <= err_flag_next;
      rx_hold     <= rx_hold_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (step) begin
      res.scl       <= line_levels_next[1];
      res.sda_out   <= line_levels_next[0];
      res.busy_res  <= (seq_state_next != S_IDLE);
      res.done_res  <= done;
      res.rx_byte   <= rx_hold_next;
      res.ack_error <= err_flag_next;
    end
  end

  // a finishing beat never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.done_res) |-> !res.busy_res)
    else $error("done beat reports busy");

  // phase counter stays below the phase length in timed phases
  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    (seq_state != S_IDLE && seq_state != S_AK_WAIT) |-> (phase_count < pt))
    else $error("phase counter past phase length");

  // a write start clears the error flag
  a_write_clears_err: assert property (@(posedge clk) disable iff (rst)
    (step && seq_state == S_IDLE && q_item.cmd == CMD_WRITE) |=> !err_flag)
    else $error("error flag not cleared by write");

  // start hold phase drives scl high with sda low
  a_start_lines: assert property (@(posedge clk) disable iff (rst)
    (seq_state == S_ST_B) |-> (line_levels == 2'b10))
    else $error("start condition line levels wrong");

endmodule

@@ src/i2c_bit_level_master.sv @@
// Path: an accepted input beat is written into the queue, then a sequencer
// step puts its result beat in the output register. Throughput: one beat per
// cycle unless the queue is full or the output stalls; the sequencer steps
// once per queued tick. Reset: synchronous, active high; sequencer idle,
// lines released, queue empty, phase_ticks 2, ack_timeout 250.
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// Tick-driven i2c master: front end classifies beats, a short queue feeds the
// bus sequencer, an apb-style port holds the phase and timeout registers.
// ----------------------------------------------------------------------------
module i2c_bit_level_master
  import i2cbm_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
)(
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [7:0]  tx_byte,
  input  logic        send_nack,
  input  logic        sda_in,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl,
  output logic        sda_out,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  rx_byte,
  output logic        ack_error,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  q_item_t front_item;
  q_item_t q_item;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  res_t    res;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_ticks <= PHASE_TICKS_RST;
      cfg.ack_timeout <= ACK_TIMEOUT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_PHASE_TICKS: cfg.phase_ticks <= pwdata[7:0];
        REG_ACK_TIMEOUT: cfg.ack_timeout <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[2])
      REG_PHASE_TICKS: prdata = {24'd0, cfg.phase_ticks};
      REG_ACK_TIMEOUT: prdata = {24'd0, cfg.ack_timeout};
      default:         prdata = '0;
    endcase
  end

  // front end
  i2cbm_front u_front (
    .opcode    (opcode),
    .tx_byte   (tx_byte),
    .send_nack (send_nack),
    .sda_in    (sda_in),
    .item      (front_item)
  );

  assign in_stall = q_full;

  // command queue
  i2cbm_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (q_item)
  );

  // bus sequencer
  i2cbm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // result beat fields
  assign scl       = res.scl;
  assign sda_out   = res.sda_out;
  assign busy_res  = res.busy_res;
  assign done_res  = res.done_res;
  assign rx_byte   = res.rx_byte;
  assign ack_error = res.ack_error;

endmodule
